>>> rtl/core/sphere_indenter_contact_force_top_defines.svh
// Assertion macros shared by the indenter force block.
`ifndef SPHERE_INDENTER_CONTACT_FORCE_TOP_DEFINES_SVH
`define SPHERE_INDENTER_CONTACT_FORCE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is held.
`define SICF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sicf assertion failed");
// Clocked check that also holds across reset.
`define SICF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sicf reset assertion failed");
`else
`define SICF_ASSERT(lbl, prop)
`define SICF_ASSERT_RST(lbl, prop)
`endif
`endif

>>> rtl/core/sicf_pkg.sv
package sicf_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned SumW      = 48;
  localparam int unsigned MagW      = 31;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned AccW      = 96;
  localparam int unsigned FmagW     = 62;
  localparam int unsigned QuoW      = 33;
  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned DivSteps  = 33;
  localparam int unsigned CntW      = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned AxisW     = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STIFFNESS  = 3'd0,
    CFG_RADIUS     = 3'd1,
    CFG_CENTER_X   = 3'd2,
    CFG_CENTER_Y   = 3'd3,
    CFG_CENTER_Z   = 3'd4,
    CFG_GROUP_BITS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] pos_z;
    logic                    has_mass;
    logic [DataW-1:0]        member_bits;
    logic signed [DataW-1:0] body_in_x;
    logic signed [DataW-1:0] body_in_y;
    logic signed [DataW-1:0] body_in_z;
    logic                    last_particle;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] body_out_x;
    logic signed [DataW-1:0] body_out_y;
    logic signed [DataW-1:0] body_out_z;
    logic signed [SumW-1:0]  sum_x;
    logic signed [SumW-1:0]  sum_y;
    logic signed [SumW-1:0]  sum_z;
    logic                    in_contact;
    logic                    step_done;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_R, ST_CHECK, ST_SQRT,
    ST_GSQ, ST_KLO, ST_KHI, ST_FMAG, ST_DIV_INIT, ST_DIV,
    ST_F_LO, ST_F_HI, ST_F_ACC, ST_F_CAP, ST_FINISH
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SQ_R, OP_CHECK, OP_SQRT,
    OP_GSQ, OP_KLO, OP_KHI, OP_FMAG, OP_DIV_INIT, OP_DIV,
    OP_F_LO, OP_F_HI, OP_F_ACC, OP_F_CAP, OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_ADD, ACC_ADD_HI
  } acc_mode_e;

  typedef struct packed {
    op_e              op;
    logic [AxisW-1:0] axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_force;
    logic out_free;
  } dp_status_t;

  // Clamp a wide signed sum to the 32-bit output range.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // Clamp a wide signed sum to the 48-bit total range.
  function automatic logic signed [SumW-1:0] sat48(input logic signed [63:0] v);
    logic signed [SumW-1:0] r;
    if (v > 64'sd140737488355327) begin
      r = 48'sh7FFFFFFFFFFF;
    end else if (v < -64'sd140737488355328) begin
      r = 48'sh800000000000;
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/sicf_stream_if.sv
// Input word channel.
interface sicf_in_if import sicf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result word channel.
interface sicf_out_if import sicf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sphere_indenter_contact_force_top.sv
// A particle that gets no force goes through the squaring and sphere check states only; one
// in contact also runs a bit-serial square root, a bit-serial divide and the force steps,
// all on one shared multiplier. The pass waits in FINISH while the result register is full.
// A new word is taken once the previous one has moved into the result register, which
// holds it until the sink takes it.
// Reset (asynchronous, active low) clears the controller state, the configuration registers,
// the running totals and the result valid flag.
`include "sphere_indenter_contact_force_top_defines.svh"

module sphere_indenter_contact_force_top import sicf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  sicf_in_if.sink            in_i,
  sicf_out_if.source         out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  sicf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and result register.
  sicf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  // A word is taken only once per pass; the block is busy right after.
  `SICF_ASSERT(a_busy_after_accept, in_i.valid && in_i.ready |=> !in_i.ready)
  // A result only appears after the block has been working on a word.
  `SICF_ASSERT(a_result_after_work, $rose(out_o.valid) |-> $past(!in_i.ready))
  // No result is presented straight out of reset.
  `SICF_ASSERT_RST(a_reset_no_result, !rst_ni |=> !out_o.valid)

endmodule

>>> rtl/core/sicf_ctrl.sv
module sicf_ctrl import sicf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AxisW-1:0] axis_q, axis_d;

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SQ_X;
      end
      ST_SQ_X: state_d = ST_SQ_Y;
      ST_SQ_Y: state_d = ST_SQ_Z;
      ST_SQ_Z: state_d = ST_SQ_R;
      ST_SQ_R: state_d = ST_CHECK;
      ST_CHECK: begin
        cnt_d   = '0;
        state_d = status_i.need_force ? ST_SQRT : ST_FINISH;
      end
      ST_SQRT: begin
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_GSQ;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_GSQ:  state_d = ST_KLO;
      ST_KLO:  state_d = ST_KHI;
      ST_KHI:  state_d = ST_FMAG;
      ST_FMAG: state_d = ST_DIV_INIT;
      ST_DIV_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CntW'(DivSteps - 1)) begin
          cnt_d   = '0;
          axis_d  = '0;
          state_d = ST_F_LO;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_F_LO:  state_d = ST_F_HI;
      ST_F_HI:  state_d = ST_F_ACC;
      ST_F_ACC: state_d = ST_F_CAP;
      ST_F_CAP: begin
        if (axis_q == AxisW'(NumAxes - 1)) begin
          state_d = ST_FINISH;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_F_LO;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.axis = axis_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = in_valid_i ? OP_LOAD : OP_NONE;
      end
      ST_SQ_X:     cmd_o.op = OP_SQ_X;
      ST_SQ_Y:     cmd_o.op = OP_SQ_Y;
      ST_SQ_Z:     cmd_o.op = OP_SQ_Z;
      ST_SQ_R:     cmd_o.op = OP_SQ_R;
      ST_CHECK:    cmd_o.op = OP_CHECK;
      ST_SQRT:     cmd_o.op = OP_SQRT;
      ST_GSQ:      cmd_o.op = OP_GSQ;
      ST_KLO:      cmd_o.op = OP_KLO;
      ST_KHI:      cmd_o.op = OP_KHI;
      ST_FMAG:     cmd_o.op = OP_FMAG;
      ST_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      ST_DIV:      cmd_o.op = OP_DIV;
      ST_F_LO:     cmd_o.op = OP_F_LO;
      ST_F_HI:     cmd_o.op = OP_F_HI;
      ST_F_ACC:    cmd_o.op = OP_F_ACC;
      ST_F_CAP:    cmd_o.op = OP_F_CAP;
      ST_FINISH:   cmd_o.op = status_i.out_free ? OP_FINISH : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

endmodule

>>> rtl/core/sicf_datapath.sv
module sicf_datapath import sicf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  in_word_t           in_data_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output out_word_t          out_data_o
);

  // Configuration registers.
  logic [DataW-1:0]        stiff_q;
  logic [MagW-1:0]         radius_q;
  logic signed [DataW-1:0] cen_q [NumAxes];
  logic [DataW-1:0]        group_q;

  // Item registers.
  logic [MagW-1:0]         mag_q   [NumAxes];
  logic                    neg_q   [NumAxes];
  logic signed [DataW-1:0] body_q  [NumAxes];
  logic                    qual_q;
  logic                    last_q;
  logic                    contact_q;

  // Arithmetic registers.
  logic [ProdW-1:0]        prod_q;
  acc_mode_e               acc_mode_q;
  logic [AccW-1:0]         acc_q;
  logic [MagW-1:0]         root_q;
  logic [32:0]             srem_q;
  logic [FmagW-1:0]        rad_sh_q;
  logic [29:0]             g2hi_q;
  logic [FmagW-1:0]        fmag_q;
  logic [QuoW-1:0]         quo_q   [NumAxes];
  logic [DataW-1:0]        drem_q  [NumAxes];
  logic [FmagW-1:0]        force_q [NumAxes];

  // Output registers.
  logic signed [SumW-1:0]  total_q [NumAxes];
  logic                    out_valid_q;
  out_word_t               out_q;

  // Combinational signals.
  logic signed [DataW-1:0] pos_a  [NumAxes];
  logic signed [DataW-1:0] bin_a  [NumAxes];
  logic signed [32:0]      d_a    [NumAxes];
  logic [32:0]             absd_a [NumAxes];
  logic [NumAxes-1:0]      box_ok;
  logic signed [32:0]      rad_s;
  logic [DataW-1:0]        mul_a, mul_b;
  acc_mode_e               mode_d;
  logic [MagW-1:0]         gap;
  logic [ProdW-1:0]        s_val;
  logic                    in_sphere;
  logic [34:0]             rem_t, trial;
  logic                    sq_fit;
  logic [34:0]             sq_rem;
  logic [DataW-1:0]        ddiff  [NumAxes];
  logic                    dfit   [NumAxes];
  logic signed [63:0]      f_s    [NumAxes];
  logic signed [DataW-1:0] bsat   [NumAxes];
  logic signed [SumW-1:0]  tsat   [NumAxes];
  logic                    finish;

  assign finish = (cmd_i.op == OP_FINISH);

  // Input lanes and the box screen around the sphere center.
  assign pos_a[0] = in_data_i.pos_x;
  assign pos_a[1] = in_data_i.pos_y;
  assign pos_a[2] = in_data_i.pos_z;
  assign bin_a[0] = in_data_i.body_in_x;
  assign bin_a[1] = in_data_i.body_in_y;
  assign bin_a[2] = in_data_i.body_in_z;
  assign rad_s    = $signed({2'b00, radius_q});

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      d_a[a]    = 33'(pos_a[a]) - 33'(cen_q[a]);
      absd_a[a] = d_a[a][32] ? 33'(-d_a[a]) : 33'(d_a[a]);
      box_ok[a] = (d_a[a] < rad_s) && (d_a[a] > -rad_s);
    end
  end

  // Shared multiplier operand selection.
  assign gap = radius_q - root_q;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mode_d = ACC_HOLD;
    unique case (cmd_i.op)
      OP_SQ_X: begin
        mul_a  = {1'b0, mag_q[0]};
        mul_b  = {1'b0, mag_q[0]};
        mode_d = ACC_ADD;
      end
      OP_SQ_Y: begin
        mul_a  = {1'b0, mag_q[1]};
        mul_b  = {1'b0, mag_q[1]};
        mode_d = ACC_ADD;
      end
      OP_SQ_Z: begin
        mul_a  = {1'b0, mag_q[2]};
        mul_b  = {1'b0, mag_q[2]};
        mode_d = ACC_ADD;
      end
      OP_SQ_R: begin
        mul_a = {1'b0, radius_q};
        mul_b = {1'b0, radius_q};
      end
      OP_GSQ: begin
        mul_a = {1'b0, gap};
        mul_b = {1'b0, gap};
      end
      OP_KLO: begin
        mul_a  = stiff_q;
        mul_b  = prod_q[31:0];
        mode_d = ACC_ADD;
      end
      OP_KHI: begin
        mul_a  = stiff_q;
        mul_b  = {2'b00, g2hi_q};
        mode_d = ACC_ADD_HI;
      end
      OP_F_LO: begin
        mul_a  = fmag_q[31:0];
        mul_b  = quo_q[cmd_i.axis][31:0];
        mode_d = ACC_ADD;
      end
      OP_F_HI: begin
        mul_a  = {2'b00, fmag_q[FmagW-1:32]};
        mul_b  = quo_q[cmd_i.axis][31:0];
        mode_d = ACC_ADD_HI;
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mode_d = ACC_HOLD;
      end
    endcase
  end

  // Sphere test: the accumulator holds the squared distance, the product R squared.
  assign s_val     = acc_q[ProdW-1:0];
  assign in_sphere = s_val < prod_q;

  assign status_o.need_force = qual_q && in_sphere && (s_val != '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // One root bit per cycle from two radicand bits.
  assign rem_t  = {srem_q, rad_sh_q[FmagW-1:FmagW-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_fit = rem_t >= trial;
  assign sq_rem = sq_fit ? rem_t - trial : rem_t;

  // One quotient bit per cycle in each axis lane.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      dfit[a]  = drem_q[a] >= {1'b0, root_q};
      ddiff[a] = dfit[a] ? drem_q[a] - {1'b0, root_q} : drem_q[a];
    end
  end

  // Signed force, body update and running totals with saturation.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      f_s[a]  = neg_q[a] ? -$signed({2'b00, force_q[a]}) : $signed({2'b00, force_q[a]});
      bsat[a] = sat32(64'(body_q[a]) + f_s[a]);
      tsat[a] = sat48(64'(total_q[a]) + f_s[a]);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q  <= '0;
      radius_q <= '0;
      group_q  <= '0;
      for (int a = 0; a < NumAxes; a++) cen_q[a] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STIFFNESS:  stiff_q  <= cfg_data_i;
        CFG_RADIUS:     radius_q <= cfg_data_i[MagW-1:0];
        CFG_CENTER_X:   cen_q[0] <= $signed(cfg_data_i);
        CFG_CENTER_Y:   cen_q[1] <= $signed(cfg_data_i);
        CFG_CENTER_Z:   cen_q[2] <= $signed(cfg_data_i);
        CFG_GROUP_BITS: group_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state of the datapath: accumulator mode, totals, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_mode_q  <= ACC_HOLD;
      out_valid_q <= 1'b0;
      for (int a = 0; a < NumAxes; a++) total_q[a] <= '0;
    end else begin
      acc_mode_q <= mode_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        for (int a = 0; a < NumAxes; a++) total_q[a] <= last_q ? '0 : tsat[a];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Multiplier, accumulator and iterative units.
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a) * ProdW'(mul_b);

    if (cmd_i.op == OP_LOAD || cmd_i.op == OP_GSQ || cmd_i.op == OP_F_LO) begin
      acc_q <= '0;
    end else begin
      case (acc_mode_q)
        ACC_ADD:    acc_q <= acc_q + AccW'(prod_q);
        ACC_ADD_HI: acc_q <= acc_q + {prod_q, 32'd0};
        default:    acc_q <= acc_q;
      endcase
    end

    case (cmd_i.op)
      OP_LOAD: begin
        qual_q    <= in_data_i.has_mass && ((in_data_i.member_bits & group_q) != '0)
                     && (&box_ok);
        last_q    <= in_data_i.last_particle;
        contact_q <= 1'b0;
        for (int a = 0; a < NumAxes; a++) begin
          mag_q[a]   <= absd_a[a][MagW-1:0];
          neg_q[a]   <= d_a[a][32];
          body_q[a]  <= bin_a[a];
          force_q[a] <= '0;
        end
      end
      OP_CHECK: begin
        contact_q <= qual_q && in_sphere;
        rad_sh_q  <= s_val[FmagW-1:0];
        root_q    <= '0;
        srem_q    <= '0;
      end
      OP_SQRT: begin
        srem_q   <= sq_rem[32:0];
        root_q   <= {root_q[MagW-2:0], sq_fit};
        rad_sh_q <= {rad_sh_q[FmagW-3:0], 2'b00};
      end
      OP_KLO: begin
        g2hi_q <= prod_q[FmagW-1:32];
      end
      OP_DIV_INIT: begin
        fmag_q <= acc_q[93:32];
        for (int a = 0; a < NumAxes; a++) begin
          drem_q[a] <= {1'b0, mag_q[a]};
          quo_q[a]  <= '0;
        end
      end
      OP_DIV: begin
        for (int a = 0; a < NumAxes; a++) begin
          drem_q[a] <= {ddiff[a][30:0], 1'b0};
          quo_q[a]  <= {quo_q[a][QuoW-2:0], dfit[a]};
        end
      end
      OP_F_CAP: begin
        // A unit quotient means the axis carries the whole magnitude.
        force_q[cmd_i.axis] <= quo_q[cmd_i.axis][QuoW-1] ? fmag_q : acc_q[93:32];
      end
      default: ;
    endcase

    if (finish) begin
      out_q.body_out_x <= bsat[0];
      out_q.body_out_y <= bsat[1];
      out_q.body_out_z <= bsat[2];
      out_q.sum_x      <= tsat[0];
      out_q.sum_y      <= tsat[1];
      out_q.sum_z      <= tsat[2];
      out_q.in_contact <= contact_q;
      out_q.step_done  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
